// ===== rtl/core/bafr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_pkg
// Shared types and codes of the bump allocator with a first-fit run table.
// ----------------------------------------------------------------------------
package bafr_pkg;

   // result status codes
   localparam logic [2:0] ST_REUSED  = 3'd0;
   localparam logic [2:0] ST_BUMPED  = 3'd1;
   localparam logic [2:0] ST_REJECT  = 3'd2;
   localparam logic [2:0] ST_OOM     = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;
   localparam logic [2:0] ST_FREED   = 3'd5;
   localparam logic [2:0] ST_DROPPED = 3'd6;

   // configuration register indexes
   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_CAP  = 1'b1;

   localparam logic [31:0] DEFAULT_ALIGN = 32'd8;

   // outcome of testing one free run against a request
   typedef struct packed {
      logic hit;
      logic keep_tail;
      logic keep_lead;
   } fit_type;

endpackage
`default_nettype wire

// ===== rtl/core/bump_allocator_first_fit_reuse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bump_allocator_first_fit_reuse
// Heap allocator: first fit over a table of free runs, bump pointer behind.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_*) carry an allocate (req_kind 0: size, align) or a
//   free (req_kind 1: address, size). Each word yields one response word
//   (rsp_*) with the address, a status code and the running statistics.
//   The free-run table lives in one RAM with a registered read port.
//   A rejected, ignored or dropped word passes through decode, finish and
//   output; a free passes through decode, push, finish and output. An
//   allocate scans the table newest first, one entry a cycle through the
//   RAM read port, then on a hit closes the gap by copying the runs above
//   it down one slot, one a cycle, and pushes the kept sliver; with no hit
//   it bumps. One word is in work at a time and the next is taken in the
//   cycle after the response is loaded.
//   The response sits in an output register; a new request is taken while
//   it waits, and the block only stalls at its final step if rsp_ready is low.
//   Reset empties the table and clears all totals, base and capacity. A write
//   of heap_capacity does the same with the bump pointer at heap_base; the
//   table RAM is never cleared, its fill count covers it.
// ----------------------------------------------------------------------------
module bump_allocator_first_fit_reuse #(
   parameter int FREE_SLOTS = 32,
   parameter int NODE_BYTES = 16,
   parameter int ADDR_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] req_align,
   input  wire logic [31:0] req_free_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_addr,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_out_live_bytes,
   output logic [31:0]      rsp_out_peak_bytes,
   output logic [31:0]      rsp_out_free_bytes,
   output logic [31:0]      rsp_out_alloc_count,
   output logic [31:0]      rsp_out_release_count,
   output logic [31:0]      rsp_out_reuse_count,
   output logic [31:0]      rsp_out_oom_count
);

   localparam int IDXW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CNTW = $clog2(FREE_SLOTS + 1);
   localparam int WB   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
   localparam int RW   = ADDR_BITS + 32;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;
   localparam logic [2:0] S_BUMP  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [ADDR_BITS-1:0] end_ff, end_in;
   logic [31:0]          cap_ff, cap_in;
   logic [CNTW-1:0]      entries_ff, entries_in;
   logic [ADDR_BITS-1:0] bump_ff, bump_in;
   logic [31:0]          live_ff, live_in;
   logic [31:0]          peak_ff, peak_in;
   logic [31:0]          span_sum_ff, span_sum_in;
   logic [31:0]          alloc_ff, alloc_in;
   logic [31:0]          release_ff, release_in;
   logic [31:0]          reuse_ff, reuse_in;
   logic [31:0]          oom_ff, oom_in;

   logic                 kind_ff, kind_in;
   logic [31:0]          size_ff, size_in;
   logic [31:0]          align_ff, align_in;
   logic [ADDR_BITS-1:0] faddr_ff, faddr_in;
   logic [2:0]           status_ff, status_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] tail_ff, tail_in;

   logic                 rd_more_ff, rd_more_in;
   logic [IDXW-1:0]      rd_idx_ff, rd_idx_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [IDXW-1:0]      ev_idx_ff, ev_idx_in;
   logic [CNTW-1:0]      sh_rd_ff, sh_rd_in;
   logic                 sh_wv_ff, sh_wv_in;
   logic [IDXW-1:0]      sh_wa_ff, sh_wa_in;
   logic                 push_en_ff, push_en_in;
   logic [ADDR_BITS-1:0] push_start_ff, push_start_in;
   logic [31:0]          push_span_ff, push_span_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_live_ff, rsp_live_in;
   logic [31:0]          rsp_peak_ff, rsp_peak_in;
   logic [31:0]          rsp_free_ff, rsp_free_in;
   logic [31:0]          rsp_alloc_ff, rsp_alloc_in;
   logic [31:0]          rsp_release_ff, rsp_release_in;
   logic [31:0]          rsp_reuse_ff, rsp_reuse_in;
   logic [31:0]          rsp_oom_ff, rsp_oom_in;

   // table RAM ports
   logic                 ram_wr_en;
   logic [IDXW-1:0]      ram_wr_addr;
   logic [RW-1:0]        ram_wr_data;
   logic                 ram_rd_en;
   logic [IDXW-1:0]      ram_rd_addr;
   logic [RW-1:0]        ram_rd_data;

   // fit check of the run at the RAM output
   logic [ADDR_BITS-1:0] fit_place;
   logic [ADDR_BITS-1:0] fit_keep_start;
   logic [31:0]          fit_keep_span;
   bafr_pkg::fit_type    fit;

   // decode and bump helpers
   logic [31:0]          align_eff;
   logic [31:0]          mask;
   logic [ADDR_BITS-1:0] mask_a;
   logic [ADDR_BITS-1:0] bump_place;
   logic                 bump_fail;
   logic                 sh_rd_go;
   logic [32:0]          live_sum;
   logic [WB:0]          free_sum;

   bafr_ram #(
      .WIDTH (RW),
      .DEPTH (FREE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bafr_fit #(
      .ADDR_BITS  (ADDR_BITS),
      .NODE_BYTES (NODE_BYTES)
   ) u_fit (
      .run_start  (ram_rd_data[RW-1:32]),
      .run_span   (ram_rd_data[31:0]),
      .size       (size_ff),
      .mask       (mask),
      .place      (fit_place),
      .keep_start (fit_keep_start),
      .keep_span  (fit_keep_span),
      .fit        (fit)
   );

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_addr       = rsp_addr_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_out_live_bytes    = rsp_live_ff;
   assign rsp_out_peak_bytes    = rsp_peak_ff;
   assign rsp_out_free_bytes    = rsp_free_ff;
   assign rsp_out_alloc_count   = rsp_alloc_ff;
   assign rsp_out_release_count = rsp_release_ff;
   assign rsp_out_reuse_count   = rsp_reuse_ff;
   assign rsp_out_oom_count     = rsp_oom_ff;

   always_comb begin
      // align and size are already adjusted after decode
      align_eff  = (align_ff == 32'd0) ? bafr_pkg::DEFAULT_ALIGN : align_ff;
      mask       = align_ff - 32'd1;
      mask_a     = ADDR_BITS'(mask);
      bump_place = (bump_ff + mask_a) & ~mask_a;
      bump_fail  = (bump_place < bump_ff) || (bump_place >= end_ff)
                   || (WB'(size_ff) > WB'(end_ff - bump_place));
      sh_rd_go   = (sh_rd_ff < entries_ff);
      live_sum   = {1'b0, live_ff} + {1'b0, size_ff};
      free_sum   = (WB + 1)'(tail_ff) + (WB + 1)'(span_sum_ff);
   end

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      end_in         = end_ff;
      cap_in         = cap_ff;
      entries_in     = entries_ff;
      bump_in        = bump_ff;
      live_in        = live_ff;
      peak_in        = peak_ff;
      span_sum_in    = span_sum_ff;
      alloc_in       = alloc_ff;
      release_in     = release_ff;
      reuse_in       = reuse_ff;
      oom_in         = oom_ff;
      kind_in        = kind_ff;
      size_in        = size_ff;
      align_in       = align_ff;
      faddr_in       = faddr_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      tail_in        = tail_ff;
      rd_more_in     = rd_more_ff;
      rd_idx_in      = rd_idx_ff;
      ev_valid_in    = 1'b0;
      ev_idx_in      = ev_idx_ff;
      sh_rd_in       = sh_rd_ff;
      sh_wv_in       = 1'b0;
      sh_wa_in       = sh_wa_ff;
      push_en_in     = push_en_ff;
      push_start_in  = push_start_ff;
      push_span_in   = push_span_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_release_in = rsp_release_ff;
      rsp_reuse_in   = rsp_reuse_ff;
      rsp_oom_in     = rsp_oom_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = sh_wa_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               size_in  = req_size;
               align_in = req_align;
               faddr_in = ADDR_BITS'(req_free_addr);
               addr_in  = '0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            // settle defaults, then route the word
            align_in = align_eff;
            if (size_ff < 32'(NODE_BYTES)) begin
               size_in = 32'(NODE_BYTES);
            end
            if (kind_ff) begin
               if ((faddr_ff == '0) || (faddr_ff < base_ff) || (faddr_ff >= end_ff)) begin
                  status_in = bafr_pkg::ST_IGNORED;
                  state_in  = S_FIN;
               end else if (entries_ff >= CNTW'(FREE_SLOTS)) begin
                  status_in = bafr_pkg::ST_DROPPED;
                  state_in  = S_FIN;
               end else begin
                  status_in     = bafr_pkg::ST_FREED;
                  push_start_in = faddr_ff;
                  push_span_in  = (size_ff < 32'(NODE_BYTES)) ? 32'(NODE_BYTES) : size_ff;
                  state_in      = S_PUSH;
               end
            end else if ((size_ff == 32'd0) || ((align_eff & (align_eff - 32'd1)) != 32'd0)) begin
               status_in = bafr_pkg::ST_REJECT;
               state_in  = S_FIN;
            end else if (entries_ff == '0) begin
               state_in = S_BUMP;
            end else begin
               rd_idx_in  = IDXW'(entries_ff - CNTW'(1));
               rd_more_in = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue the next read while the previous run is tested
            ram_rd_en   = rd_more_ff;
            ram_rd_addr = rd_idx_ff;
            if (rd_more_ff) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = rd_idx_ff;
               rd_idx_in   = rd_idx_ff - IDXW'(1);
               rd_more_in  = (rd_idx_ff != '0);
            end
            if (ev_valid_ff && fit.hit) begin
               ev_valid_in   = 1'b0;
               status_in     = bafr_pkg::ST_REUSED;
               addr_in       = fit_place;
               push_en_in    = fit.keep_tail || fit.keep_lead;
               push_start_in = fit_keep_start;
               push_span_in  = fit_keep_span;
               span_sum_in   = span_sum_ff - ram_rd_data[31:0];
               sh_rd_in      = CNTW'(ev_idx_ff) + CNTW'(1);
               state_in      = S_SHIFT;
            end else if (ev_valid_ff && (ev_idx_ff == '0)) begin
               ev_valid_in = 1'b0;
               state_in    = S_BUMP;
            end
         end
         S_SHIFT: begin
            // move runs above the hole down one slot
            ram_rd_en   = sh_rd_go;
            ram_rd_addr = IDXW'(sh_rd_ff);
            ram_wr_en   = sh_wv_ff;
            if (sh_rd_go) begin
               sh_wv_in = 1'b1;
               sh_wa_in = IDXW'(sh_rd_ff - CNTW'(1));
               sh_rd_in = sh_rd_ff + CNTW'(1);
            end else if (!sh_wv_ff) begin
               entries_in = entries_ff - CNTW'(1);
               state_in   = push_en_ff ? S_PUSH : S_FIN;
            end
         end
         S_PUSH: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDXW'(entries_ff);
            ram_wr_data = {push_start_ff, push_span_ff};
            entries_in  = entries_ff + CNTW'(1);
            span_sum_in = span_sum_ff + push_span_ff;
            state_in    = S_FIN;
         end
         S_BUMP: begin
            if (bump_fail) begin
               status_in = bafr_pkg::ST_OOM;
            end else begin
               status_in = bafr_pkg::ST_BUMPED;
               addr_in   = bump_place;
               bump_in   = bump_place + ADDR_BITS'(size_ff);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            tail_in = (bump_ff <= end_ff) ? (end_ff - bump_ff) : '0;
            case (status_ff) inside
               bafr_pkg::ST_REUSED, bafr_pkg::ST_BUMPED: begin
                  alloc_in = alloc_ff + 32'd1;
                  live_in  = live_sum[32] ? 32'hFFFF_FFFF : live_sum[31:0];
                  if (status_ff == bafr_pkg::ST_REUSED) begin
                     reuse_in = reuse_ff + 32'd1;
                  end
               end
               bafr_pkg::ST_OOM: begin
                  oom_in = oom_ff + 32'd1;
               end
               bafr_pkg::ST_FREED: begin
                  release_in = release_ff + 32'd1;
                  live_in    = (push_span_ff <= live_ff) ? (live_ff - push_span_ff) : 32'd0;
               end
               default: begin
               end
            endcase
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               peak_in        = (live_ff > peak_ff) ? live_ff : peak_ff;
               rsp_valid_in   = 1'b1;
               rsp_addr_in    = 32'(WB'(addr_ff));
               rsp_status_in  = status_ff;
               rsp_live_in    = live_ff;
               rsp_peak_in    = (live_ff > peak_ff) ? live_ff : peak_ff;
               rsp_free_in    = (free_sum > (WB + 1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                       : free_sum[31:0];
               rsp_alloc_in   = alloc_ff;
               rsp_release_in = release_ff;
               rsp_reuse_in   = reuse_ff;
               rsp_oom_in     = oom_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block does not enforce this
      if (csr_wr_en) begin
         unique case (csr_index)
            bafr_pkg::CSR_HEAP_BASE: begin
               base_in = ADDR_BITS'(csr_wr_data);
               end_in  = ADDR_BITS'(csr_wr_data) + ADDR_BITS'(cap_ff);
            end
            bafr_pkg::CSR_HEAP_CAP: begin
               cap_in      = csr_wr_data;
               end_in      = base_ff + ADDR_BITS'(csr_wr_data);
               entries_in  = '0;
               bump_in     = base_ff;
               live_in     = '0;
               peak_in     = '0;
               span_sum_in = '0;
               alloc_in    = '0;
               release_in  = '0;
               reuse_in    = '0;
               oom_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         end_ff       <= '0;
         cap_ff       <= '0;
         entries_ff   <= '0;
         bump_ff      <= '0;
         live_ff      <= '0;
         peak_ff      <= '0;
         span_sum_ff  <= '0;
         alloc_ff     <= '0;
         release_ff   <= '0;
         reuse_ff     <= '0;
         oom_ff       <= '0;
         rd_more_ff   <= 1'b0;
         ev_valid_ff  <= 1'b0;
         sh_wv_ff     <= 1'b0;
         push_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         end_ff       <= end_in;
         cap_ff       <= cap_in;
         entries_ff   <= entries_in;
         bump_ff      <= bump_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         span_sum_ff  <= span_sum_in;
         alloc_ff     <= alloc_in;
         release_ff   <= release_in;
         reuse_ff     <= reuse_in;
         oom_ff       <= oom_in;
         rd_more_ff   <= rd_more_in;
         ev_valid_ff  <= ev_valid_in;
         sh_wv_ff     <= sh_wv_in;
         push_en_ff   <= push_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      size_ff        <= size_in;
      align_ff       <= align_in;
      faddr_ff       <= faddr_in;
      status_ff      <= status_in;
      addr_ff        <= addr_in;
      tail_ff        <= tail_in;
      rd_idx_ff      <= rd_idx_in;
      ev_idx_ff      <= ev_idx_in;
      sh_rd_ff       <= sh_rd_in;
      sh_wa_ff       <= sh_wa_in;
      push_start_ff  <= push_start_in;
      push_span_ff   <= push_span_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_alloc_ff   <= rsp_alloc_in;
      rsp_release_ff <= rsp_release_in;
      rsp_reuse_ff   <= rsp_reuse_in;
      rsp_oom_ff     <= rsp_oom_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= CNTW'(FREE_SLOTS))
      else $error("run table fill count above capacity");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DEC))
      else $error("accepted word did not enter decode");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |-> (entries_ff < CNTW'(FREE_SLOTS)))
      else $error("push into a full run table");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bafr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bafr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bafr_fit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_fit
// Tests one free run against an aligned request and sizes the kept sliver.
// ----------------------------------------------------------------------------
module bafr_fit #(
   parameter int ADDR_BITS  = 32,
   parameter int NODE_BYTES = 16
) (
   input  wire logic [ADDR_BITS-1:0] run_start,
   input  wire logic [31:0]          run_span,
   input  wire logic [31:0]          size,
   input  wire logic [31:0]          mask,
   output logic      [ADDR_BITS-1:0] place,
   output logic      [ADDR_BITS-1:0] keep_start,
   output logic      [31:0]          keep_span,
   output bafr_pkg::fit_type         fit
);

   localparam int WB = (ADDR_BITS > 32) ? ADDR_BITS : 32;

   logic [ADDR_BITS-1:0] mask_a;
   logic [ADDR_BITS-1:0] lead;
   logic [31:0]          lead32;
   logic [31:0]          room;
   logic [31:0]          tail;

   always_comb begin
      mask_a = ADDR_BITS'(mask);
      place  = (run_start + mask_a) & ~mask_a;
      lead   = place - run_start;
      lead32 = 32'(lead);
      room   = run_span - size;
      tail   = room - lead32;
      fit.hit = (place >= run_start) && (size <= run_span) && (WB'(lead) <= WB'(room));
      fit.keep_tail = (tail >= 32'(NODE_BYTES)) && (tail >= lead32);
      fit.keep_lead = !fit.keep_tail && (lead32 >= 32'(NODE_BYTES));
      keep_start = fit.keep_tail ? (place + ADDR_BITS'(size)) : run_start;
      keep_span  = fit.keep_tail ? tail : lead32;
   end

endmodule
`default_nettype wire
